[rtl/sse_pkg.sv]
// shared types and codes for the sorted set engine
`timescale 1ns / 1ps

package sse_pkg;

    localparam int SSE_CAPACITY = 16;

    localparam int CMD_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_CHANGED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOCHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic cmp;
        logic ins;
        logic rem;
    } t_cell_ctl;

endpackage

[rtl/sse_cell.sv]
// one slot of the sorted row: holds an entry, compares it, shifts with neighbors
`timescale 1ns / 1ps

module sse_cell
    import sse_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctl                 i_ctl,
    input  logic                      i_valid,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_left_lt,
    input  logic signed [VALUE_W-1:0] i_left_entry,
    input  logic signed [VALUE_W-1:0] i_right_entry,
    output logic signed [VALUE_W-1:0] o_entry,
    output logic                      o_lt,
    output logic                      o_eq
);

    logic signed [VALUE_W-1:0] r_entry;
    logic                      r_lt;
    logic                      r_eq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_lt <= i_valid && (r_entry < i_value);
            r_eq <= i_valid && (r_entry == i_value);
        end
    end

    // slots at or above the sorted position move: up on insert, down on remove
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && !r_lt) begin
            r_entry <= i_left_lt ? i_value : i_left_entry;
        end else if (i_ctl.rem && !r_lt) begin
            r_entry <= i_right_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

[rtl/sorted_set_engine_core.sv]
// sorted set engine: row of compare-and-shift cells holding ascending entries
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------
//  command   | start, busy             | i_cmd, i_value
//  result    | o_valid (one-cycle)     | o_was_present, o_status, o_count
//
// a transaction loads the compare flags of all cells when it is accepted, then
// shifts the row and registers the result in the update state.
// busy is high for that one update cycle, so a new command can be accepted in
// the cycle the result strobe is shown; no command is taken during the update.
// synchronous active-low reset empties the set; the entries need no clearing.
// the receiver cannot stall, so results are never held back.
`timescale 1ns / 1ps

module sorted_set_engine_core
    import sse_pkg::*;
#(
    parameter int CAPACITY = SSE_CAPACITY
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [CMD_W-1:0]           i_cmd,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_valid,
    output logic                       o_was_present,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COUNT_W-1:0]         o_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                      r_state;
    logic [CMD_W-1:0]          r_cmd;
    logic signed [VALUE_W-1:0] r_value;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;

    logic                      r_valid;
    logic                      r_was_present;
    logic [STATUS_W-1:0]       r_status;

    logic                      accept;
    t_cell_ctl                 ctl;
    logic signed [VALUE_W-1:0] cell_value;
    logic                      present;
    logic                      do_ins;
    logic                      do_rem;
    logic                      full;
    logic [STATUS_W-1:0]       n_status;
    logic [CW+COUNT_W-1:0]     count_wide;

    logic signed [VALUE_W-1:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0]       w_lt;
    logic [CAPACITY-1:0]       w_eq;

    assign busy   = (r_state == ST_UPD);
    assign accept = start && !busy;

    assign present = |w_eq;
    assign full    = (r_count >= CW'(CAPACITY));
    assign do_ins  = busy && (r_cmd == CMD_INSERT) && !present && !full;
    assign do_rem  = busy && (r_cmd == CMD_REMOVE) && present;

    assign ctl.cmp = accept;
    assign ctl.ins = do_ins;
    assign ctl.rem = do_rem;

    // compare against the incoming command, insert the latched one
    assign cell_value = busy ? r_value : i_value;

    always_comb begin
        n_status = ST_NOCHANGE;
        n_count  = r_count;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (!present) begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_CHANGED;
                        n_count  = r_count + CW'(1);
                    end
                end
            end
            CMD_REMOVE: begin
                if (present) begin
                    n_status = ST_CHANGED;
                    n_count  = r_count - CW'(1);
                end
            end
            default: begin
                n_status = ST_NOCHANGE;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                      left_lt;
            logic signed [VALUE_W-1:0] left_entry;
            logic signed [VALUE_W-1:0] right_entry;
            logic                      slot_valid;

            if (gi == 0) begin : g_first
                assign left_lt    = 1'b1;
                assign left_entry = r_value;
            end else begin : g_mid
                assign left_lt    = w_lt[gi-1];
                assign left_entry = w_entry[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_entry = w_entry[gi];
            end else begin : g_inner
                assign right_entry = w_entry[gi+1];
            end

            assign slot_valid = (r_count > CW'(gi));

            sse_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (ctl),
                .i_valid       (slot_valid),
                .i_value       (cell_value),
                .i_left_lt     (left_lt),
                .i_left_entry  (left_entry),
                .i_right_entry (right_entry),
                .o_entry       (w_entry[gi]),
                .o_lt          (w_lt[gi]),
                .o_eq          (w_eq[gi])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= busy;
            if (accept) begin
                r_state <= ST_UPD;
            end else if (busy) begin
                r_state <= ST_IDLE;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_value <= i_value;
        end
        if (busy) begin
            r_was_present <= present;
            r_status      <= n_status;
        end
    end

    assign count_wide    = (CW + COUNT_W)'(r_count);
    assign o_valid       = r_valid;
    assign o_was_present = r_was_present;
    assign o_status      = r_status;
    assign o_count       = count_wide[COUNT_W-1:0];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid && !busy)
        else $error("update cycle did not produce a result");

    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> !o_was_present && (r_count == CW'(CAPACITY)))
        else $error("full refusal with room left or value present");

    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> $onehot0(w_eq))
        else $error("value matched more than one entry");
`endif

endmodule
